// ===== rtl/dasp_pkg.sv =====
// Shared types and constants for the distance attenuation / stereo pan unit.
// Used by dasp_norm, the top level and the checker; depends on nothing.
package dasp_pkg;

	localparam int POS_W   = 20;          // Q15.4 signed position
	localparam int DIFF_W  = POS_W + 1;   // source minus listener
	localparam int MAG_W   = POS_W;       // magnitude of a difference
	localparam int SQ_W    = 2 * MAG_W;   // one squared axis
	localparam int ROOT_W  = DIFF_W;      // distance
	localparam int RAD_W   = 2 * ROOT_W;  // sum of three squares
	localparam int COMP_W  = 16;          // Q1.14 orientation component
	localparam int VEC_W   = 3 * COMP_W;
	localparam int PROD_W  = DIFF_W + COMP_W;
	localparam int DOT_W   = PROD_W + 1;
	localparam int DIST_W  = 19;
	localparam int FRAC_W  = 17;          // quotient bits of both dividers
	localparam int VNUM_W  = ROOT_W + 16; // (d - min) << 16
	localparam int PNUM_W  = DOT_W + 1;   // |2 * dot|
	localparam int PDEN_W  = ROOT_W + 1;  // d + 1
	localparam int CFG_W   = VEC_W;
	localparam int IDX_W   = 3;
	localparam int TAG_W   = 5;

	localparam logic [16:0] ONE16   = 17'd65536;
	localparam logic [16:0] PAN_MID = 17'd32768;

	localparam logic [VEC_W-1:0]  FWD_RESET = 48'h4000_0000_0000;
	localparam logic [VEC_W-1:0]  UP_RESET  = 48'h0000_4000_0000;
	localparam logic [DIST_W-1:0] MIN_RESET = 19'd160;
	localparam logic [DIST_W-1:0] MAX_RESET = 19'd1600;
	// right vector of the reset orientation, already normalized
	localparam logic signed [COMP_W-1:0] NX_RESET = -16'sd16384;
	localparam logic signed [COMP_W-1:0] NZ_RESET = 16'sd0;

	typedef enum logic [IDX_W-1:0] {
		REG_LISTENER_X = 3'd0,
		REG_LISTENER_Y = 3'd1,
		REG_LISTENER_Z = 3'd2,
		REG_FORWARD    = 3'd3,
		REG_UP         = 3'd4,
		REG_MIN_DIST   = 3'd5,
		REG_MAX_DIST   = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		NORM_IDLE,
		NORM_CROSS,
		NORM_SQUARE,
		NORM_SUM,
		NORM_ROOT,
		NORM_DIVX,
		NORM_DIVZ
	} norm_state_t;

	typedef struct packed {
		logic [TAG_W-1:0]        channel_tag;
		logic signed [POS_W-1:0] source_x;
		logic signed [POS_W-1:0] source_y;
		logic signed [POS_W-1:0] source_z;
	} in_word_t;

	typedef struct packed {
		logic [TAG_W-1:0] channel_out;
		logic [7:0]       vol_level;
		logic [16:0]      pan_fraction;
		logic [7:0]       left_gain;
		logic [7:0]       right_gain;
	} out_word_t;

endpackage

// ===== rtl/dasp_norm.sv =====
// Normalizes the listener right vector (forward x up, x and z only) to Q1.14.
// Sequential unit restarted by orientation writes; uses dasp_pkg.
module dasp_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [dasp_pkg::VEC_W-1:0]           fwd,
	input  logic [dasp_pkg::VEC_W-1:0]           up,
	output logic                                 busy,
	output logic signed [dasp_pkg::COMP_W-1:0]   nx,
	output logic signed [dasp_pkg::COMP_W-1:0]   nz
);
	dasp_pkg::norm_state_t state_q, state_nx;

	logic signed [15:0] fx, fy, fz, ux, uy, uz;
	logic signed [31:0] p_yz, p_zy, p_xy, p_yx;
	logic signed [32:0] rx_q, rz_q;
	logic [31:0]        mx_q, mz_q;
	logic [63:0]        sqx_q, sqz_q, rad_q;
	logic [33:0]        rem_q, rem_sh, rem_nx;
	logic [31:0]        root_q, root_nx;
	logic [4:0]         cnt_q;
	logic [46:0]        drem_q, dsh;
	logic [14:0]        dq_q, dq_nx;
	logic               rge, dge, last;
	logic signed [15:0] qsig;

	assign fx = $signed(fwd[15:0]);
	assign fy = $signed(fwd[31:16]);
	assign fz = $signed(fwd[47:32]);
	assign ux = $signed(up[15:0]);
	assign uy = $signed(up[31:16]);
	assign uz = $signed(up[47:32]);
	assign p_yz = fy * uz;
	assign p_zy = fz * uy;
	assign p_xy = fx * uy;
	assign p_yx = fy * ux;

	// one root bit per cycle
	assign rem_sh  = {rem_q[31:0], rad_q[63:62]};
	assign rge     = rem_sh >= {root_q, 2'b01};
	assign rem_nx  = rge ? rem_sh - {root_q, 2'b01} : rem_sh;
	assign root_nx = {root_q[30:0], rge};

	// one quotient bit per cycle, divisor shifted by the bit index
	assign dsh   = 47'(root_q) << cnt_q[3:0];
	assign dge   = (root_q != 32'd0) && (drem_q >= dsh);
	assign dq_nx = {dq_q[13:0], dge};
	assign qsig  = $signed({1'b0, dq_nx});
	assign last  = (cnt_q == 5'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= dasp_pkg::NORM_IDLE;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			dasp_pkg::NORM_IDLE:   if (start) state_nx = dasp_pkg::NORM_CROSS;
			dasp_pkg::NORM_CROSS:  state_nx = dasp_pkg::NORM_SQUARE;
			dasp_pkg::NORM_SQUARE: state_nx = dasp_pkg::NORM_SUM;
			dasp_pkg::NORM_SUM:    state_nx = dasp_pkg::NORM_ROOT;
			dasp_pkg::NORM_ROOT:   if (last) state_nx = dasp_pkg::NORM_DIVX;
			dasp_pkg::NORM_DIVX:   if (last) state_nx = dasp_pkg::NORM_DIVZ;
			dasp_pkg::NORM_DIVZ:   if (last) state_nx = dasp_pkg::NORM_IDLE;
			default:               state_nx = dasp_pkg::NORM_IDLE;
		endcase
		// a later orientation write starts over with the new vectors
		if (start) state_nx = dasp_pkg::NORM_CROSS;
	end

	assign busy = (state_q != dasp_pkg::NORM_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			nx    <= dasp_pkg::NX_RESET;
			nz    <= dasp_pkg::NZ_RESET;
		end else begin
			case (state_q)
				dasp_pkg::NORM_SUM:  cnt_q <= 5'd31;
				dasp_pkg::NORM_ROOT: cnt_q <= last ? 5'd14 : cnt_q - 5'd1;
				dasp_pkg::NORM_DIVX: begin
					cnt_q <= last ? 5'd14 : cnt_q - 5'd1;
					if (last) nx <= rx_q[32] ? -qsig : qsig;
				end
				dasp_pkg::NORM_DIVZ: begin
					cnt_q <= last ? 5'd0 : cnt_q - 5'd1;
					if (last) nz <= rz_q[32] ? -qsig : qsig;
				end
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			dasp_pkg::NORM_CROSS: begin
				rx_q <= 33'(p_yz) - 33'(p_zy);
				rz_q <= 33'(p_xy) - 33'(p_yx);
			end
			dasp_pkg::NORM_SQUARE: begin
				mx_q  <= rx_q[32] ? 32'(-rx_q) : rx_q[31:0];
				mz_q  <= rz_q[32] ? 32'(-rz_q) : rz_q[31:0];
				sqx_q <= 64'(rx_q[32] ? 32'(-rx_q) : rx_q[31:0])
					* 64'(rx_q[32] ? 32'(-rx_q) : rx_q[31:0]);
				sqz_q <= 64'(rz_q[32] ? 32'(-rz_q) : rz_q[31:0])
					* 64'(rz_q[32] ? 32'(-rz_q) : rz_q[31:0]);
			end
			dasp_pkg::NORM_SUM: begin
				rad_q  <= sqx_q + sqz_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			dasp_pkg::NORM_ROOT: begin
				rem_q  <= rem_nx;
				root_q <= root_nx;
				rad_q  <= {rad_q[61:0], 2'b00};
				if (last) begin
					drem_q <= {1'b0, mx_q, 14'd0};
					dq_q   <= '0;
				end
			end
			dasp_pkg::NORM_DIVX: begin
				if (last) begin
					drem_q <= {1'b0, mz_q, 14'd0};
					dq_q   <= '0;
				end else begin
					drem_q <= dge ? drem_q - dsh : drem_q;
					dq_q   <= dq_nx;
				end
			end
			dasp_pkg::NORM_DIVZ: begin
				drem_q <= dge ? drem_q - dsh : drem_q;
				dq_q   <= dq_nx;
			end
			default: dq_q <= dq_q;
		endcase
	end
endmodule

// ===== rtl/dasp_sqrt.sv =====
// Pipelined integer square root, one root bit per stage, side data carried along.
// Generic; no package dependency.
module dasp_sqrt #(
	parameter int N      = 21,
	parameter int SIDE_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [2*N-1:0]    rad,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [N-1:0]      root,
	output logic [SIDE_W-1:0] side_out
);
	logic [2*N-1:0]    rad_s  [N];
	logic [N+1:0]      rem_s  [N];
	logic [N-1:0]      root_s [N];
	logic [SIDE_W-1:0] side_s [N];
	logic              vld_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [2*N-1:0]    rad_p;
		logic [N+1:0]      rem_p, rem_sh, trial;
		logic [N-1:0]      root_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p, ge;

		if (k == 0) begin : g_first
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
			assign side_p = side_in;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign rem_sh = {rem_p[N-1:0], rad_p[2*N-1 -: 2]};
		assign trial  = {root_p, 2'b01};
		assign ge     = rem_sh >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[2*N-3:0], 2'b00};
				rem_s[k]  <= ge ? rem_sh - trial : rem_sh;
				root_s[k] <= {root_p[N-2:0], ge};
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[N-1];
	assign root     = root_s[N-1];
	assign side_out = side_s[N-1];
endmodule

// ===== rtl/dasp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, side data carried along.
// Generic; no package dependency.
module dasp_div #(
	parameter int NUM_W  = 37,
	parameter int DEN_W  = 19,
	parameter int Q_W    = 17,
	parameter int SIDE_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [Q_W-1:0]    quo,
	output logic [SIDE_W-1:0] side_out
);
	localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [W-1:0]      rem_s  [Q_W];
	logic [Q_W-1:0]    q_s    [Q_W];
	logic [DEN_W-1:0]  den_s  [Q_W];
	logic [SIDE_W-1:0] side_s [Q_W];
	logic              vld_s  [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [W-1:0]      rem_p, dsh;
		logic [Q_W-1:0]    q_p;
		logic [DEN_W-1:0]  den_p;
		logic [SIDE_W-1:0] side_p;
		logic              vld_p, ge;

		if (k == 0) begin : g_first
			assign rem_p  = W'(num);
			assign q_p    = '0;
			assign den_p  = den;
			assign side_p = side_in;
			assign vld_p  = in_vld;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign q_p    = q_s[k-1];
			assign den_p  = den_s[k-1];
			assign side_p = side_s[k-1];
			assign vld_p  = vld_s[k-1];
		end

		assign dsh = W'(den_p) << (Q_W - 1 - k);
		assign ge  = rem_p >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k] <= 1'b0;
			else if (en) vld_s[k] <= vld_p;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? rem_p - dsh : rem_p;
				q_s[k]    <= {q_p[Q_W-2:0], ge};
				den_s[k]  <= den_p;
				side_s[k] <= side_p;
			end
		end
	end

	assign out_vld  = vld_s[Q_W-1];
	assign quo      = q_s[Q_W-1];
	assign side_out = side_s[Q_W-1];
endmodule

// ===== rtl/distance_attenuation_stereo_pan_unit.sv =====
// Top level of the distance attenuation / stereo pan unit.
// Depends on dasp_pkg, dasp_norm, dasp_sqrt and dasp_div.
//
// Usage: in_data carries a channel tag and a source position (Q15.4) on a
// valid/ready channel; out_data returns the tag, mixer volume (0..128), pan
// (Q1.16) and 8-bit left/right gains on a valid/ready channel. Listener
// position, orientation and the min/max distances are written through
// cfg_we/cfg_index/cfg_data; the user must write them only while no word
// is in flight, as the block itself does not enforce it. Throughput: one
// word per cycle unless the output stalls or the normalizer is busy. An
// accepted word passes 43 register stages (3 front, 21 square-root, 1
// setup, 17 divider, 1 output register) to out_valid. A write to the forward
// or up vector (re)starts the right-vector normalizer, which holds in_ready
// low after the last such write until its root and two quotients are done.
// Reset empties the pipeline and loads the default listener: origin,
// facing +z with +y up, min 10.0, max 100.0; no clearing pass is needed.
// When the receiver stalls, the whole pipeline freezes in place with the
// output register held; no word is dropped or repeated.
module distance_attenuation_stereo_pan_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  dasp_pkg::in_word_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output dasp_pkg::out_word_t               out_data,
	input  logic                              cfg_we,
	input  logic [dasp_pkg::IDX_W-1:0]        cfg_index,
	input  logic [dasp_pkg::CFG_W-1:0]        cfg_data
);
	localparam int SQ_SIDE_W = dasp_pkg::TAG_W + dasp_pkg::DOT_W;
	localparam int PD_SIDE_W = dasp_pkg::TAG_W + 1;

	// configuration
	logic signed [dasp_pkg::POS_W-1:0] lx_q, ly_q, lz_q;
	logic [dasp_pkg::VEC_W-1:0]        fwd_q, up_q;
	logic [dasp_pkg::DIST_W-1:0]       min_q, max_q;
	logic signed [dasp_pkg::COMP_W-1:0] nx, nz;
	logic                              norm_busy, norm_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q  <= '0;
			ly_q  <= '0;
			lz_q  <= '0;
			fwd_q <= dasp_pkg::FWD_RESET;
			up_q  <= dasp_pkg::UP_RESET;
			min_q <= dasp_pkg::MIN_RESET;
			max_q <= dasp_pkg::MAX_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				dasp_pkg::REG_LISTENER_X: lx_q  <= cfg_data[dasp_pkg::POS_W-1:0];
				dasp_pkg::REG_LISTENER_Y: ly_q  <= cfg_data[dasp_pkg::POS_W-1:0];
				dasp_pkg::REG_LISTENER_Z: lz_q  <= cfg_data[dasp_pkg::POS_W-1:0];
				dasp_pkg::REG_FORWARD:    fwd_q <= cfg_data;
				dasp_pkg::REG_UP:         up_q  <= cfg_data;
				dasp_pkg::REG_MIN_DIST:   min_q <= cfg_data[dasp_pkg::DIST_W-1:0];
				dasp_pkg::REG_MAX_DIST:   max_q <= cfg_data[dasp_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	assign norm_start = cfg_we && (cfg_index == dasp_pkg::REG_FORWARD
		|| cfg_index == dasp_pkg::REG_UP);

	dasp_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.fwd    (fwd_q),
		.up     (up_q),
		.busy   (norm_busy),
		.nx     (nx),
		.nz     (nz)
	);

	// global advance: every pipeline stage moves unless the output word is stuck
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en && !norm_busy;

	// stage 1: offsets
	logic                               vld_s1;
	logic [dasp_pkg::TAG_W-1:0]         tag_s1;
	logic signed [dasp_pkg::DIFF_W-1:0] dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (en) vld_s1 <= in_valid && in_ready;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_data.channel_tag;
			dx_s1  <= dasp_pkg::DIFF_W'(in_data.source_x) - dasp_pkg::DIFF_W'(lx_q);
			dy_s1  <= dasp_pkg::DIFF_W'(in_data.source_y) - dasp_pkg::DIFF_W'(ly_q);
			dz_s1  <= dasp_pkg::DIFF_W'(in_data.source_z) - dasp_pkg::DIFF_W'(lz_q);
		end
	end

	// stage 2: squares and dot terms
	logic [dasp_pkg::MAG_W-1:0]         mx, my, mz;
	logic                               vld_s2;
	logic [dasp_pkg::TAG_W-1:0]         tag_s2;
	logic [dasp_pkg::SQ_W-1:0]          sqx_s2, sqy_s2, sqz_s2;
	logic signed [dasp_pkg::PROD_W-1:0] px_s2, pz_s2;

	assign mx = dasp_pkg::MAG_W'(dx_s1[dasp_pkg::DIFF_W-1] ? -dx_s1 : dx_s1);
	assign my = dasp_pkg::MAG_W'(dy_s1[dasp_pkg::DIFF_W-1] ? -dy_s1 : dy_s1);
	assign mz = dasp_pkg::MAG_W'(dz_s1[dasp_pkg::DIFF_W-1] ? -dz_s1 : dz_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (en) vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s2 <= tag_s1;
			sqx_s2 <= dasp_pkg::SQ_W'(mx) * dasp_pkg::SQ_W'(mx);
			sqy_s2 <= dasp_pkg::SQ_W'(my) * dasp_pkg::SQ_W'(my);
			sqz_s2 <= dasp_pkg::SQ_W'(mz) * dasp_pkg::SQ_W'(mz);
			px_s2  <= dasp_pkg::PROD_W'(dx_s1) * dasp_pkg::PROD_W'(nx);
			pz_s2  <= dasp_pkg::PROD_W'(dz_s1) * dasp_pkg::PROD_W'(nz);
		end
	end

	// stage 3: radicand and dot product
	logic                              vld_s3;
	logic [dasp_pkg::TAG_W-1:0]        tag_s3;
	logic [dasp_pkg::RAD_W-1:0]        rad_s3;
	logic signed [dasp_pkg::DOT_W-1:0] dot_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (en) vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3 <= tag_s2;
			rad_s3 <= dasp_pkg::RAD_W'(sqx_s2) + dasp_pkg::RAD_W'(sqy_s2)
				+ dasp_pkg::RAD_W'(sqz_s2);
			dot_s3 <= dasp_pkg::DOT_W'(px_s2) + dasp_pkg::DOT_W'(pz_s2);
		end
	end

	// distance
	logic                         sq_vld;
	logic [dasp_pkg::ROOT_W-1:0]  dist_root;
	logic [SQ_SIDE_W-1:0]         sq_side;

	dasp_sqrt #(
		.N      (dasp_pkg::ROOT_W),
		.SIDE_W (SQ_SIDE_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.rad      (rad_s3),
		.side_in  ({tag_s3, dot_s3}),
		.out_vld  (sq_vld),
		.root     (dist_root),
		.side_out (sq_side)
	);

	// stage 4: divider operands and volume range flags
	logic signed [dasp_pkg::DOT_W-1:0] sq_dot;
	logic [dasp_pkg::ROOT_W:0]         dist_x, min_x, max_x;
	logic                              full_c, zero_c;
	logic                              vld_s4, full_s4, zero_s4, neg_s4;
	logic [dasp_pkg::TAG_W-1:0]        tag_s4;
	logic [dasp_pkg::VNUM_W-1:0]       vnum_s4;
	logic [dasp_pkg::DIST_W-1:0]       vden_s4;
	logic [dasp_pkg::PNUM_W-1:0]       pnum_s4;
	logic [dasp_pkg::PDEN_W-1:0]       pden_s4;

	assign sq_dot = sq_side[dasp_pkg::DOT_W-1:0];
	assign dist_x = (dasp_pkg::ROOT_W + 1)'(dist_root);
	assign min_x  = (dasp_pkg::ROOT_W + 1)'(min_q);
	assign max_x  = (dasp_pkg::ROOT_W + 1)'(max_q);
	assign full_c = (max_q <= min_q) || (dist_x < min_x);
	assign zero_c = dist_x > max_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (en) vld_s4 <= sq_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s4  <= sq_side[SQ_SIDE_W-1 -: dasp_pkg::TAG_W];
			full_s4 <= full_c;
			zero_s4 <= zero_c;
			vnum_s4 <= (full_c || zero_c) ? '0
				: {dasp_pkg::ROOT_W'(dist_x - min_x), 16'd0};
			vden_s4 <= max_q - min_q;
			neg_s4  <= sq_dot[dasp_pkg::DOT_W-1];
			pnum_s4 <= {dasp_pkg::DOT_W'(sq_dot[dasp_pkg::DOT_W-1] ? -sq_dot : sq_dot),
				1'b0};
			pden_s4 <= dasp_pkg::PDEN_W'(dist_root) + dasp_pkg::PDEN_W'(1);
		end
	end

	// volume and pan quotients
	logic                          vd_vld, pd_vld;
	logic [dasp_pkg::FRAC_W-1:0]   vquo, pquo;
	logic [1:0]                    vd_side;
	logic [PD_SIDE_W-1:0]          pd_side;

	dasp_div #(
		.NUM_W  (dasp_pkg::VNUM_W),
		.DEN_W  (dasp_pkg::DIST_W),
		.Q_W    (dasp_pkg::FRAC_W),
		.SIDE_W (2)
	) u_vdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (vnum_s4),
		.den      (vden_s4),
		.side_in  ({full_s4, zero_s4}),
		.out_vld  (vd_vld),
		.quo      (vquo),
		.side_out (vd_side)
	);

	dasp_div #(
		.NUM_W  (dasp_pkg::PNUM_W),
		.DEN_W  (dasp_pkg::PDEN_W),
		.Q_W    (dasp_pkg::FRAC_W),
		.SIDE_W (PD_SIDE_W)
	) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s4),
		.num      (pnum_s4),
		.den      (pden_s4),
		.side_in  ({tag_s4, neg_s4}),
		.out_vld  (pd_vld),
		.quo      (pquo),
		.side_out (pd_side)
	);

	// output stage: volume select, pan clamp, gains
	logic [16:0]        vol, pan, lrest;
	logic signed [18:0] pan_raw;
	logic [24:0]        lmul, rmul;

	always_comb begin
		if (vd_side[1]) vol = dasp_pkg::ONE16;
		else if (vd_side[0]) vol = '0;
		else vol = dasp_pkg::ONE16 - vquo;

		pan_raw = pd_side[0] ? 19'(dasp_pkg::PAN_MID) - 19'(pquo)
			: 19'(dasp_pkg::PAN_MID) + 19'(pquo);
		if (pan_raw < 0) pan = '0;
		else if (pan_raw > 19'(dasp_pkg::ONE16)) pan = dasp_pkg::ONE16;
		else pan = pan_raw[16:0];

		lrest = dasp_pkg::ONE16 - pan;
		lmul  = {lrest, 8'd0} - 25'(lrest);
		rmul  = {pan, 8'd0} - 25'(pan);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vd_vld && pd_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.channel_out  <= pd_side[PD_SIDE_W-1 -: dasp_pkg::TAG_W];
			out_data.vol_level    <= vol[16:9];
			out_data.pan_fraction <= pan;
			out_data.left_gain    <= lmul[23:16];
			out_data.right_gain   <= rmul[23:16];
		end
	end
endmodule

// ===== rtl/dasp_checker.sv =====
// Port-level checks for the distance attenuation / stereo pan unit, bound to the top.
// Depends on dasp_pkg and distance_attenuation_stereo_pan_unit.
module dasp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input dasp_pkg::out_word_t out_data
);
	logic [8:0] gain_sum;
	assign gain_sum = {1'b0, out_data.left_gain} + {1'b0, out_data.right_gain};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_vol_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.vol_level <= 8'd128)
		else $error("mix volume above full scale");

	a_pan_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.pan_fraction <= 17'd65536)
		else $error("pan outside 0..1");

	a_gain_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> gain_sum == 9'd254 || gain_sum == 9'd255)
		else $error("left and right gains do not complement");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");
endmodule

bind distance_attenuation_stereo_pan_unit dasp_checker u_dasp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
